FILE: hw/rtl/qce_pkg.sv
// shared constants, types and tables for the calibrated euler angle block
package qce_pkg;

   localparam int FRAC                 = 14;
   localparam int MAX_SAMPLES_DEFAULT  = 4096;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam int SUM_W   = 28;
   localparam int CNT_W   = 13;
   localparam int QIN_W   = 16;
   localparam int QR_W    = 20;
   localparam int ACC_W   = 34;
   localparam int PROD_W  = 40;
   localparam int TERM_W  = 48;
   localparam int ANG_W   = 15;
   localparam int PITCH_W = 14;
   localparam int Z_W     = 28;
   localparam int RAD_W   = 62;
   localparam int ROOT_W  = 31;
   localparam int M30_W   = 30;

   localparam int M30_SHIFT   = 30 - 2 * FRAC;
   localparam int ROLL_LIMIT  = 11520;
   localparam int PITCH_LIMIT = 5760;

   localparam logic [CNT_W-1:0]         SAMPLE_COUNT_RESET = 13'd100;
   localparam logic signed [QIN_W-1:0]  QUAT_ONE  = QIN_W'(1 << FRAC);
   localparam logic signed [ACC_W-1:0]  QUAT_HALF = ACC_W'(1 << (FRAC - 1));
   localparam logic signed [TERM_W-1:0] EUL_ONE   = TERM_W'(1) << (2 * FRAC);
   localparam logic [RAD_W-1:0]         SQRT_ONE  = RAD_W'(1) << 60;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_MEASURE = 2'd1,
      OP_RAW     = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_SAMPLE_COUNT = 2'd0,
      REG_TARGET_BODY  = 2'd1
   } reg_index_type;

   // atan(2^-i) in degrees scaled by 2^16
   function automatic logic [21:0] atan_entry(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117305;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   // sign of reference-times-input term k of the conjugate product
   // (component k[3:2], reference index k[1:0], input index k[1:0]^k[3:2])
   function automatic logic qmul_neg(input logic [3:0] k);
      logic n;
      case (k)
         4'd5, 4'd6, 4'd10, 4'd11, 4'd13, 4'd15: n = 1'b1;
         default:                                n = 1'b0;
      endcase
      return n;
   endfunction

   // operand pairs of the nine euler products: wz xy zz xx wx yz wy xz yy
   function automatic logic [1:0] eul_opa(input logic [3:0] k);
      logic [1:0] v;
      case (k)
         4'd0, 4'd4, 4'd6: v = 2'd0;
         4'd1, 4'd3, 4'd7: v = 2'd1;
         4'd5, 4'd8:       v = 2'd2;
         default:          v = 2'd3;
      endcase
      return v;
   endfunction

   function automatic logic [1:0] eul_opb(input logic [3:0] k);
      logic [1:0] v;
      case (k)
         4'd3, 4'd4:       v = 2'd1;
         4'd1, 4'd6, 4'd8: v = 2'd2;
         default:          v = 2'd3;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/qce_div.sv
// restoring divider for the calibration averages, one quotient bit per cycle
module qce_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [qce_pkg::SUM_W-1:0]  dividend,
   input  logic [qce_pkg::CNT_W-1:0]         divisor,
   output logic                              done,
   output logic signed [qce_pkg::QIN_W-1:0]  quotient
);

   localparam int NW = qce_pkg::SUM_W;
   localparam int DW = qce_pkg::CNT_W;
   localparam int CW = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic signed [qce_pkg::QIN_W-1:0] res_ff, res_in;

   logic [DW:0]   trial;
   logic          ge;
   logic [NW-1:0] quo_next;

   always_comb begin
      trial    = {rem_ff, num_ff[NW-1]};
      ge       = trial >= {1'b0, div_ff};
      quo_next = {quo_ff[NW-2:0], ge};

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      res_in  = res_ff;

      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend < 0;
         num_in  = dividend < 0 ? NW'(-dividend) : NW'(dividend);
         quo_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
         num_in = {num_ff[NW-2:0], 1'b0};
         quo_in = quo_next;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // truncation toward zero, then wrap to the quaternion width
            res_in  = neg_ff ? qce_pkg::QIN_W'(-quo_next) : qce_pkg::QIN_W'(quo_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

FILE: hw/rtl/qce_sqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
module qce_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [qce_pkg::RAD_W-1:0]    radicand,
   output logic                         done,
   output logic [qce_pkg::ROOT_W-1:0]   root
);

   localparam int RW = qce_pkg::RAD_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] res_ff, res_in;
   logic [RW-1:0] bit_ff, bit_in;
   logic [RW-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;

      if (start) begin
         busy_in = 1'b1;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = RW'(1) << 60;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == RW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[qce_pkg::ROOT_W-1:0];

endmodule

FILE: hw/rtl/qce_cordic.sv
// vectoring cordic atan2, one micro-rotation per cycle, result in 1/64 degree
module qce_cordic #(
   parameter int CORDIC_STEPS = qce_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               narrow,
   input  logic signed [qce_pkg::TERM_W-1:0]  y_in,
   input  logic signed [qce_pkg::TERM_W-1:0]  x_in,
   output logic                               done,
   output logic signed [qce_pkg::ANG_W-1:0]   angle
);

   localparam int TW = qce_pkg::TERM_W;
   localparam int ZW = qce_pkg::Z_W;
   localparam int RW = ZW - 10;
   localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * 65536);
   localparam logic signed [ZW-1:0] Z_ROUND   = ZW'(512);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 narrow_ff, narrow_in;
   logic [SW-1:0]        step_ff, step_in;
   logic signed [TW-1:0] x_ff, x_in_r, y_ff, y_in_r;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [qce_pkg::ANG_W-1:0] angle_ff, angle_in;

   logic [4:0]           idx;
   logic signed [TW-1:0] dx, dy, x_step, y_step;
   logic signed [ZW-1:0] tab, z_step, z_rnd;
   logic signed [RW-1:0] r, lim, r_clamp;

   always_comb begin
      idx = 5'(step_ff);
      dx  = y_ff >>> idx;
      dy  = x_ff >>> idx;
      tab = ZW'(qce_pkg::atan_entry(idx));
      if (y_ff > 0) begin
         x_step = x_ff + dx;
         y_step = y_ff - dy;
         z_step = z_ff + tab;
      end else begin
         x_step = x_ff - dx;
         y_step = y_ff + dy;
         z_step = z_ff - tab;
      end
      z_rnd = z_step + Z_ROUND;
      r     = RW'(z_rnd >>> 10);
      lim   = narrow_ff ? RW'(qce_pkg::PITCH_LIMIT) : RW'(qce_pkg::ROLL_LIMIT);
      if (r > lim) begin
         r_clamp = lim;
      end else if (r < -lim) begin
         r_clamp = -lim;
      end else begin
         r_clamp = r;
      end

      busy_in   = busy_ff;
      done_in   = 1'b0;
      narrow_in = narrow_ff;
      step_in   = step_ff;
      x_in_r    = x_ff;
      y_in_r    = y_ff;
      z_in      = z_ff;
      angle_in  = angle_ff;

      if (start) begin
         narrow_in = narrow;
         step_in   = '0;
         if (x_in == 0 && y_in == 0) begin
            done_in  = 1'b1;
            angle_in = '0;
         end else begin
            busy_in = 1'b1;
            // left half plane: pre-rotate by a quarter turn
            if (x_in < 0 && y_in >= 0) begin
               x_in_r = y_in;
               y_in_r = -x_in;
               z_in   = Z_QUARTER;
            end else if (x_in < 0) begin
               x_in_r = -y_in;
               y_in_r = x_in;
               z_in   = -Z_QUARTER;
            end else begin
               x_in_r = x_in;
               y_in_r = y_in;
               z_in   = '0;
            end
         end
      end else if (busy_ff) begin
         x_in_r  = x_step;
         y_in_r  = y_step;
         z_in    = z_step;
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(CORDIC_STEPS - 1)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            angle_in = qce_pkg::ANG_W'(r_clamp);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      narrow_ff <= narrow_in;
      step_ff   <= step_in;
      x_ff      <= x_in_r;
      y_ff      <= y_in_r;
      z_ff      <= z_in;
      angle_ff  <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

FILE: hw/rtl/quat_calibrated_euler_angles.sv
// calibrated quaternion to roll, pitch and yaw converter, top level and sequencer
// one word at a time; sample and clear words go straight from dispatch to the result,
// a calibrating sample adds 4 divider runs, one per reference component
// measure and raw words pass through the shared multiplier (raw skips the conjugate
// product), the square root unit and three runs of the cordic unit (saturated pitch: no root, two runs)
// synchronous reset restores sample_count 100, target_body 0 and an identity reference
module quat_calibrated_euler_angles #(
   parameter int MAX_SAMPLES  = qce_pkg::MAX_SAMPLES_DEFAULT,
   parameter int CORDIC_STEPS = qce_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic [15:0]                         req_body_id,
   input  logic signed [15:0]                  req_q_w,
   input  logic signed [15:0]                  req_q_x,
   input  logic signed [15:0]                  req_q_y,
   input  logic signed [15:0]                  req_q_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [14:0]                  rsp_roll_angle,
   output logic signed [13:0]                  rsp_pitch_angle,
   output logic signed [14:0]                  rsp_yaw_angle,
   output logic                                rsp_sample_taken,
   output logic                                rsp_calibrated,
   output logic                                rsp_pitch_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [15:0]                         csr_data
);

   localparam int SW = qce_pkg::SUM_W;
   localparam int CN = qce_pkg::CNT_W;
   localparam int QI = qce_pkg::QIN_W;
   localparam int QR = qce_pkg::QR_W;
   localparam int AW = qce_pkg::ACC_W;
   localparam int PW = qce_pkg::PROD_W;
   localparam int TW = qce_pkg::TERM_W;
   localparam int GW = qce_pkg::ANG_W;
   localparam int PT = qce_pkg::PITCH_W;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_DIV_GO, ST_DIV_WAIT, ST_QMUL, ST_EMUL, ST_TERMS,
      ST_ROLL_GO, ST_ROLL_WAIT, ST_PCHK, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_PITCH_GO, ST_PITCH_WAIT, ST_YAW_GO, ST_YAW_WAIT, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CN-1:0]        samp_cnt_ff, samp_cnt_in;
   logic [15:0]          target_ff, target_in;
   logic signed [SW-1:0] sum_ff [4];
   logic signed [SW-1:0] sum_in [4];
   logic signed [QI-1:0] ref_ff [4];
   logic signed [QI-1:0] ref_in [4];
   logic [CN-1:0]        seen_ff, seen_in;
   logic                 cal_ff, cal_in;

   qce_pkg::op_type      op_ff, op_in;
   logic [15:0]          body_ff, body_in;
   logic signed [QI-1:0] a_ff [4];
   logic signed [QI-1:0] a_in [4];

   logic [4:0]           k_ff, k_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [63:0]   prod_ff;
   logic signed [QR-1:0] qw_ff, qw_in, qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic signed [PW-1:0] p_ff [9];
   logic signed [PW-1:0] p_in [9];
   logic signed [TW-1:0] sr_ff, sr_in, cr_ff, cr_in, sp_ff, sp_in;
   logic signed [TW-1:0] sy_ff, sy_in, cy_ff, cy_in;
   logic [qce_pkg::M30_W-1:0]  m30_ff, m30_in;
   logic [qce_pkg::ROOT_W-1:0] c_ff, c_in;
   logic                 psign_ff, psign_in;

   logic signed [GW-1:0] roll_ff, roll_in, yaw_ff, yaw_in;
   logic signed [PT-1:0] pitch_ff, pitch_in;
   logic                 taken_ff, taken_in, sat_ff, sat_in;

   // shared multiplier and datapath helpers
   logic signed [31:0]   mul_a, mul_b;
   logic signed [63:0]   mul_p;
   logic signed [31:0]   prod_lo;
   logic [3:0]           ks;
   logic signed [AW-1:0] qterm, qacc, qround;
   logic signed [QR-1:0] qval;
   logic signed [TW-1:0] pe [9];
   logic signed [TW-1:0] sp_abs;
   logic [CN-1:0]        need, seen_next;

   logic                 div_start, div_done;
   logic signed [QI-1:0] div_quot;
   logic                 sqrt_start, sqrt_done;
   logic [qce_pkg::RAD_W-1:0]  sqrt_rad;
   logic [qce_pkg::ROOT_W-1:0] sqrt_root;
   logic                 cor_start, cor_narrow, cor_done;
   logic signed [TW-1:0] cor_y, cor_x;
   logic signed [GW-1:0] cor_angle;

   function automatic logic signed [QR-1:0] pick_q(input logic [1:0] sel,
         input logic signed [QR-1:0] w, input logic signed [QR-1:0] x,
         input logic signed [QR-1:0] y, input logic signed [QR-1:0] z);
      logic signed [QR-1:0] v;
      case (sel)
         2'd0:    v = w;
         2'd1:    v = x;
         2'd2:    v = y;
         default: v = z;
      endcase
      return v;
   endfunction

   assign mul_p   = mul_a * mul_b;
   assign prod_lo = prod_ff[31:0];
   assign ks      = 4'(k_ff - 5'd1);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_QMUL: begin
            mul_a = 32'(ref_ff[k_ff[1:0]]);
            mul_b = 32'(a_ff[k_ff[1:0] ^ k_ff[3:2]]);
         end
         ST_EMUL: begin
            mul_a = 32'(pick_q(qce_pkg::eul_opa(k_ff[3:0]), qw_ff, qx_ff, qy_ff, qz_ff));
            mul_b = 32'(pick_q(qce_pkg::eul_opb(k_ff[3:0]), qw_ff, qx_ff, qy_ff, qz_ff));
         end
         ST_SQ: begin
            mul_a = 32'(m30_ff);
            mul_b = 32'(m30_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      // conjugate product term, accumulated per component
      qterm  = qce_pkg::qmul_neg(ks) ? -AW'(prod_lo) : AW'(prod_lo);
      qacc   = ((ks[1:0] == 2'd0) ? AW'(0) : acc_ff) + qterm;
      qround = qacc + qce_pkg::QUAT_HALF;
      qval   = QR'(qround >>> qce_pkg::FRAC);
      for (int i = 0; i < 9; i++) begin
         pe[i] = TW'(p_ff[i]);
      end
      sp_abs = sp_ff < 0 ? -sp_ff : sp_ff;

      if (samp_cnt_ff == '0) begin
         need = CN'(1);
      end else if (32'(samp_cnt_ff) > MAX_SAMPLES) begin
         need = CN'(MAX_SAMPLES);
      end else begin
         need = samp_cnt_ff;
      end
      seen_next = seen_ff + CN'(1);
      sqrt_rad  = qce_pkg::SQRT_ONE - prod_ff[qce_pkg::RAD_W-1:0];
   end

   assign div_start  = state_ff == ST_DIV_GO;
   assign sqrt_start = state_ff == ST_SQRT_GO;
   assign cor_start  = state_ff == ST_ROLL_GO || state_ff == ST_PITCH_GO
                       || state_ff == ST_YAW_GO;
   assign cor_narrow = state_ff == ST_PITCH_GO;

   always_comb begin
      case (state_ff)
         ST_PITCH_GO: begin
            cor_y = TW'(m30_ff);
            cor_x = TW'(c_ff);
         end
         ST_YAW_GO: begin
            cor_y = sy_ff;
            cor_x = cy_ff;
         end
         default: begin
            cor_y = sr_ff;
            cor_x = cr_ff;
         end
      endcase
   end

   qce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[k_ff[1:0]]),
      .divisor  (seen_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   qce_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   qce_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .narrow (cor_narrow),
      .y_in   (cor_y),
      .x_in   (cor_x),
      .done   (cor_done),
      .angle  (cor_angle)
   );

   always_comb begin
      state_in    = state_ff;
      samp_cnt_in = samp_cnt_ff;
      target_in   = target_ff;
      seen_in     = seen_ff;
      cal_in      = cal_ff;
      op_in       = op_ff;
      body_in     = body_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      qw_in       = qw_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      qz_in       = qz_ff;
      sr_in       = sr_ff;
      cr_in       = cr_ff;
      sp_in       = sp_ff;
      sy_in       = sy_ff;
      cy_in       = cy_ff;
      m30_in      = m30_ff;
      c_in        = c_ff;
      psign_in    = psign_ff;
      roll_in     = roll_ff;
      pitch_in    = pitch_ff;
      yaw_in      = yaw_ff;
      taken_in    = taken_ff;
      sat_in      = sat_ff;
      for (int i = 0; i < 4; i++) begin
         sum_in[i] = sum_ff[i];
         ref_in[i] = ref_ff[i];
         a_in[i]   = a_ff[i];
      end
      for (int i = 0; i < 9; i++) begin
         p_in[i] = p_ff[i];
      end

      if (csr_valid) begin
         if (csr_index == qce_pkg::REG_SAMPLE_COUNT) begin
            samp_cnt_in = csr_data[CN-1:0];
         end else if (csr_index == qce_pkg::REG_TARGET_BODY) begin
            target_in = csr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = qce_pkg::op_type'(req_operation);
               body_in  = req_body_id;
               a_in[0]  = req_q_w;
               a_in[1]  = req_q_x;
               a_in[2]  = req_q_y;
               a_in[3]  = req_q_z;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            roll_in  = '0;
            pitch_in = '0;
            yaw_in   = '0;
            taken_in = 1'b0;
            sat_in   = 1'b0;
            k_in     = '0;
            state_in = ST_DONE;
            case (op_ff)
               qce_pkg::OP_SAMPLE: begin
                  if (!cal_ff && body_ff == target_ff) begin
                     for (int i = 0; i < 4; i++) begin
                        sum_in[i] = sum_ff[i] + SW'(a_ff[i]);
                     end
                     seen_in  = seen_next;
                     taken_in = 1'b1;
                     if (seen_next >= need) begin
                        state_in = ST_DIV_GO;
                     end
                  end
               end
               qce_pkg::OP_MEASURE: begin
                  state_in = ST_QMUL;
               end
               qce_pkg::OP_RAW: begin
                  qw_in    = QR'(a_ff[0]);
                  qx_in    = QR'(a_ff[1]);
                  qy_in    = QR'(a_ff[2]);
                  qz_in    = QR'(a_ff[3]);
                  state_in = ST_EMUL;
               end
               default: begin
                  for (int i = 0; i < 4; i++) begin
                     sum_in[i] = '0;
                     ref_in[i] = '0;
                  end
                  ref_in[0] = qce_pkg::QUAT_ONE;
                  seen_in   = '0;
                  cal_in    = 1'b0;
               end
            endcase
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               ref_in[k_ff[1:0]] = div_quot;
               if (k_ff[1:0] == 2'd3) begin
                  cal_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 5'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_QMUL: begin
            // product of step k is registered in prod_ff and accumulated as step k-1
            if (k_ff != '0) begin
               acc_in = qacc;
               if (ks[1:0] == 2'd3) begin
                  case (ks[3:2])
                     2'd0:    qw_in = qval;
                     2'd1:    qx_in = qval;
                     2'd2:    qy_in = qval;
                     default: qz_in = qval;
                  endcase
               end
            end
            if (k_ff == 5'd16) begin
               k_in     = '0;
               state_in = ST_EMUL;
            end else begin
               k_in = k_ff + 5'd1;
            end
         end
         ST_EMUL: begin
            if (k_ff != '0) begin
               p_in[ks] = prod_ff[PW-1:0];
            end
            if (k_ff == 5'd9) begin
               k_in     = '0;
               state_in = ST_TERMS;
            end else begin
               k_in = k_ff + 5'd1;
            end
         end
         ST_TERMS: begin
            sr_in    = (pe[0] + pe[1]) <<< 1;
            cr_in    = qce_pkg::EUL_ONE - ((pe[2] + pe[3]) <<< 1);
            sp_in    = (pe[4] - pe[5]) <<< 1;
            sy_in    = (pe[6] + pe[7]) <<< 1;
            cy_in    = qce_pkg::EUL_ONE - ((pe[3] + pe[8]) <<< 1);
            state_in = ST_ROLL_GO;
         end
         ST_ROLL_GO: begin
            state_in = ST_ROLL_WAIT;
         end
         ST_ROLL_WAIT: begin
            if (cor_done) begin
               roll_in  = cor_angle;
               state_in = ST_PCHK;
            end
         end
         ST_PCHK: begin
            if (sp_ff >= qce_pkg::EUL_ONE || sp_ff <= -qce_pkg::EUL_ONE) begin
               pitch_in = (sp_ff > 0) ? PT'(qce_pkg::PITCH_LIMIT) : -PT'(qce_pkg::PITCH_LIMIT);
               sat_in   = 1'b1;
               state_in = ST_YAW_GO;
            end else begin
               m30_in   = qce_pkg::M30_W'(sp_abs <<< qce_pkg::M30_SHIFT);
               psign_in = sp_ff < 0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            state_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               c_in     = sqrt_root;
               state_in = ST_PITCH_GO;
            end
         end
         ST_PITCH_GO: begin
            state_in = ST_PITCH_WAIT;
         end
         ST_PITCH_WAIT: begin
            if (cor_done) begin
               pitch_in = psign_ff ? -PT'(cor_angle) : PT'(cor_angle);
               state_in = ST_YAW_GO;
            end
         end
         ST_YAW_GO: begin
            state_in = ST_YAW_WAIT;
         end
         ST_YAW_WAIT: begin
            if (cor_done) begin
               yaw_in   = cor_angle;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         samp_cnt_ff <= qce_pkg::SAMPLE_COUNT_RESET;
         target_ff   <= '0;
         seen_ff     <= '0;
         cal_ff      <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= '0;
            ref_ff[i] <= '0;
         end
         ref_ff[0]   <= qce_pkg::QUAT_ONE;
      end else begin
         state_ff    <= state_in;
         samp_cnt_ff <= samp_cnt_in;
         target_ff   <= target_in;
         seen_ff     <= seen_in;
         cal_ff      <= cal_in;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= sum_in[i];
            ref_ff[i] <= ref_in[i];
         end
      end
      op_ff    <= op_in;
      body_ff  <= body_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      prod_ff  <= mul_p;
      qw_ff    <= qw_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      qz_ff    <= qz_in;
      sr_ff    <= sr_in;
      cr_ff    <= cr_in;
      sp_ff    <= sp_in;
      sy_ff    <= sy_in;
      cy_ff    <= cy_in;
      m30_ff   <= m30_in;
      c_ff     <= c_in;
      psign_ff <= psign_in;
      roll_ff  <= roll_in;
      pitch_ff <= pitch_in;
      yaw_ff   <= yaw_in;
      taken_ff <= taken_in;
      sat_ff   <= sat_in;
      for (int i = 0; i < 4; i++) begin
         a_ff[i] <= a_in[i];
      end
      for (int i = 0; i < 9; i++) begin
         p_ff[i] <= p_in[i];
      end
   end

   assign req_stall           = state_ff != ST_IDLE;
   assign rsp_valid           = state_ff == ST_DONE;
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_yaw_angle       = yaw_ff;
   assign rsp_sample_taken    = taken_ff;
   assign rsp_calibrated      = cal_ff;
   assign rsp_pitch_saturated = sat_ff;
   assign csr_ready           = 1'b1;

endmodule

FILE: hw/rtl/qce_checker.sv
// port-level checks for the calibrated euler angle block, bound to the top level
module qce_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [1:0]          req_operation,
   input logic [15:0]         req_body_id,
   input logic signed [15:0]  req_q_w,
   input logic signed [15:0]  req_q_x,
   input logic signed [15:0]  req_q_y,
   input logic signed [15:0]  req_q_z,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [14:0]  rsp_roll_angle,
   input logic signed [13:0]  rsp_pitch_angle,
   input logic signed [14:0]  rsp_yaw_angle,
   input logic                rsp_sample_taken,
   input logic                rsp_calibrated,
   input logic                rsp_pitch_saturated,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [1:0]          csr_index,
   input logic [15:0]         csr_data
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // one word in flight: input side closes right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while busy");

   a_busy_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while result pending");

   a_sat_pole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_saturated |->
         (rsp_pitch_angle == 14'sd5760 || rsp_pitch_angle == -14'sd5760))
      else $error("saturated pitch not at the pole");

   a_sample_no_angles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_taken |->
         rsp_roll_angle == 0 && rsp_pitch_angle == 0 && rsp_yaw_angle == 0
         && !rsp_pitch_saturated)
      else $error("sample word carries angles");

endmodule

bind quat_calibrated_euler_angles qce_checker u_qce_checker (.*);

FILE: bench/qce_checker.sv
// checker for the calibrated euler angle block: predicts each word and compares results
`timescale 1ns / 1ps
module qce_scoreboard (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [15:0]        req_body_id,
   input  logic signed [15:0] req_q_w,
   input  logic signed [15:0] req_q_x,
   input  logic signed [15:0] req_q_y,
   input  logic signed [15:0] req_q_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [14:0] rsp_roll_angle,
   input  logic signed [13:0] rsp_pitch_angle,
   input  logic signed [14:0] rsp_yaw_angle,
   input  logic               rsp_sample_taken,
   input  logic               rsp_calibrated,
   input  logic               rsp_pitch_saturated,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 failures,
   output int                 pending
);

   typedef struct packed {
      logic signed [14:0] roll;
      logic signed [13:0] pitch;
      logic signed [14:0] yaw;
      logic               taken;
      logic               cal;
      logic               sat;
   } angles_type;

   localparam longint ATAN_DEG [16] = '{2949120, 1740967, 919879, 466945, 234379, 117305,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   angles_type  angles_q[$];
   int unsigned count_cfg, body_cfg, seen;
   longint      acc[4];
   longint      ref_q[4];
   bit          cal_done;

   function automatic longint atan2_deg(longint y_in, longint x_in, longint lim);
      longint x, y, z, t, dx, dy, r;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * 65536;
         end else begin
            t = x; x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += ATAN_DEG[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_DEG[i];
         end
      end
      r = (z + 512) >>> 10;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v_in);
      longint unsigned v, res, b;
      v = v_in;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic void euler_of(longint w, longint x, longint y, longint z,
                                     ref angles_type o);
      longint one, sr, cr, sp, sy, cy, p;
      longint unsigned mag, m30, c;
      one = longint'(1) << 28;
      sr = 2 * (w * z + x * y);
      cr = one - 2 * (z * z + x * x);
      sp = 2 * (w * x - y * z);
      sy = 2 * (w * y + x * z);
      cy = one - 2 * (x * x + y * y);
      o.roll = 15'(atan2_deg(sr, cr, 11520));
      if (sp >= one || sp <= -one) begin
         p = sp > 0 ? 5760 : -5760;
         o.sat = 1'b1;
      end else begin
         mag = sp < 0 ? -sp : sp;
         m30 = mag << 2;
         c = floor_sqrt((64'd1 << 60) - m30 * m30);
         p = atan2_deg(longint'(m30), longint'(c), 5760);
         if (sp < 0) p = -p;
         o.sat = 1'b0;
      end
      o.pitch = 14'(p);
      o.yaw = 15'(atan2_deg(sy, cy, 11520));
   endfunction

   function automatic void drop_calibration();
      for (int i = 0; i < 4; i++) acc[i] = 0;
      ref_q[0] = 16384;
      ref_q[1] = 0;
      ref_q[2] = 0;
      ref_q[3] = 0;
      seen = 0;
      cal_done = 0;
   endfunction

   function automatic angles_type predict_angles(qce_pkg::op_type op, logic [15:0] body,
                                                 longint a[4]);
      angles_type o;
      longint r[4], iw, ix, iy, iz;
      int unsigned need;
      logic signed [27:0] s28;
      o = '0;
      case (op)
         qce_pkg::OP_SAMPLE: begin
            if (!cal_done && body == body_cfg) begin
               need = count_cfg;
               if (need < 1) need = 1;
               if (need > 4096) need = 4096;
               for (int i = 0; i < 4; i++) begin
                  s28 = 28'(acc[i] + a[i]);
                  acc[i] = s28;
               end
               seen = (seen + 1) & 32'h1fff;
               o.taken = 1'b1;
               if (seen >= need) begin
                  for (int i = 0; i < 4; i++)
                     ref_q[i] = longint'(signed'(16'(acc[i] / longint'(seen == 0 ? 1 : seen))));
                  cal_done = 1;
               end
            end
         end
         qce_pkg::OP_MEASURE: begin
            iw = ref_q[0]; ix = -ref_q[1]; iy = -ref_q[2]; iz = -ref_q[3];
            r[0] = iw * a[0] - ix * a[1] - iy * a[2] - iz * a[3];
            r[1] = iw * a[1] + ix * a[0] + iy * a[3] - iz * a[2];
            r[2] = iw * a[2] - ix * a[3] + iy * a[0] + iz * a[1];
            r[3] = iw * a[3] + ix * a[2] - iy * a[1] + iz * a[0];
            for (int i = 0; i < 4; i++) r[i] = (r[i] + 8192) >>> 14;
            euler_of(r[0], r[1], r[2], r[3], o);
         end
         qce_pkg::OP_RAW: euler_of(a[0], a[1], a[2], a[3], o);
         default: drop_calibration();
      endcase
      o.cal = cal_done;
      return o;
   endfunction

   always @(posedge clock) begin
      angles_type exp_w, got;
      longint     a[4];
      if (reset) begin
         count_cfg = 100;
         body_cfg = 0;
         drop_calibration();
         angles_q.delete();
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (qce_pkg::reg_index_type'(csr_index))
               qce_pkg::REG_SAMPLE_COUNT: count_cfg = csr_data & 16'h1fff;
               qce_pkg::REG_TARGET_BODY:  body_cfg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            a[0] = req_q_w; a[1] = req_q_x; a[2] = req_q_y; a[3] = req_q_z;
            angles_q = {angles_q,
                        predict_angles(qce_pkg::op_type'(req_operation), req_body_id, a)};
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle, rsp_sample_taken,
                    rsp_calibrated, rsp_pitch_saturated};
            if (angles_q.size() == 0) begin
               failures++;
               if (failures <= 10) $display("unexpected result word %p", got);
            end else begin
               exp_w = angles_q.pop_front();
               if (got !== exp_w) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch: expected %p, got %p", exp_w, got);
               end
            end
         end
      end
      pending = angles_q.size();
   end

endmodule

FILE: bench/tb_quat_calibrated_euler_angles.sv
// testbench top for the calibrated euler angle block: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_quat_calibrated_euler_angles;

   localparam int CYCLE_LIMIT = 2000000;

   logic               clock;
   logic               reset;
   logic               req_valid, req_stall;
   logic [1:0]         req_operation;
   logic [15:0]        req_body_id;
   logic signed [15:0] req_q_w, req_q_x, req_q_y, req_q_z;
   logic               rsp_valid, rsp_stall;
   logic signed [14:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [13:0] rsp_pitch_angle;
   logic               rsp_sample_taken, rsp_calibrated, rsp_pitch_saturated;
   logic               csr_valid, csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;
   int                 failures, pending, cycles, words_sent, stall_hold;
   logic [15:0]        target;

   quat_calibrated_euler_angles u_top (.*);

   qce_scoreboard u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side stalls in bursts, with quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2:  begin rsp_stall <= 1'b1; stall_hold <= $urandom_range(0, 3); end
            3:        begin rsp_stall <= 1'b1; stall_hold <= $urandom_range(20, 60); end
            default:  begin rsp_stall <= 1'b0; stall_hold <= $urandom_range(0, 30); end
         endcase
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(qce_pkg::op_type op, logic [15:0] body, int w, int x, int y,
                            int z);
      int g;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_body_id   <= body;
      req_q_w       <= 16'(w);
      req_q_x       <= 16'(x);
      req_q_y       <= 16'(y);
      req_q_z       <= 16'(z);
      do @(posedge clock); while (req_stall);
      words_sent++;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_reg(qce_pkg::reg_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait out every outstanding word before touching the registers
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int rand_comp();
      return $urandom_range(0, 32768) - 16384;
   endfunction

   task automatic random_word();
      int              mode, w, x, y, z, k;
      qce_pkg::op_type op;
      logic [15:0]     body;
      k = $urandom_range(0, 99);
      if (k < 40)      op = qce_pkg::OP_SAMPLE;
      else if (k < 78) op = qce_pkg::OP_MEASURE;
      else if (k < 95) op = qce_pkg::OP_RAW;
      else             op = qce_pkg::OP_CLEAR;
      body = ($urandom_range(0, 9) < 8) ? target : 16'($urandom);
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
         w = rand_comp(); x = rand_comp(); y = rand_comp(); z = rand_comp();
      end else if (mode < 8) begin
         // near a common pose, roughly unit length
         w = 13000 + $urandom_range(0, 2000); x = $urandom_range(0, 8000) - 4000;
         y = $urandom_range(0, 8000) - 4000;  z = $urandom_range(0, 8000) - 4000;
      end else begin
         // around the pitch pole
         w = $urandom_range(0, 1) ? 11585 : -11585;
         x = ($urandom_range(0, 1) ? w : -w) + $urandom_range(0, 40) - 20;
         y = $urandom_range(0, 200) - 100;
         z = $urandom_range(0, 200) - 100;
      end
      send_word(op, body, w, x, y, z);
   endtask

   initial begin
      int c;
      reset = 1'b1;
      words_sent = 0;
      req_valid = 1'b0;
      req_operation = qce_pkg::OP_SAMPLE;
      req_body_id = '0;
      req_q_w = '0; req_q_x = '0; req_q_y = '0; req_q_z = '0;
      csr_valid = 1'b0;
      csr_index = qce_pkg::REG_SAMPLE_COUNT;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      write_reg(qce_pkg::REG_SAMPLE_COUNT, 16'd2);
      write_reg(qce_pkg::REG_TARGET_BODY, 16'd5);
      target = 16'd5;
      send_word(qce_pkg::OP_RAW, 16'd0, 16384, 0, 0, 0);
      send_word(qce_pkg::OP_RAW, 16'd0, 0, 8192, 0, 8192);
      send_word(qce_pkg::OP_RAW, 16'd0, 16384, 16384, 0, 0);
      send_word(qce_pkg::OP_RAW, 16'd0, 16384, -16384, 0, 0);
      send_word(qce_pkg::OP_RAW, 16'hffff, -16384, -16384, -16384, -16384);
      send_word(qce_pkg::OP_RAW, 16'd0, -16384, 16384, 16384, 16384);
      send_word(qce_pkg::OP_RAW, 16'd0, 11585, 0, 0, -11585);
      send_word(qce_pkg::OP_MEASURE, 16'd5, 12000, 3000, -4000, 5000);
      send_word(qce_pkg::OP_SAMPLE, 16'd4, 16000, 1000, -2000, 3000);
      send_word(qce_pkg::OP_SAMPLE, 16'd5, 16000, 1000, -2000, 3000);
      send_word(qce_pkg::OP_SAMPLE, 16'd5, 15000, -1001, -2500, 2000);
      send_word(qce_pkg::OP_SAMPLE, 16'd5, 9000, 9000, 9000, 9000);
      send_word(qce_pkg::OP_MEASURE, 16'd0, 16000, 1000, -2000, 3000);
      send_word(qce_pkg::OP_CLEAR, 16'd0, 0, 0, 0, 0);
      send_word(qce_pkg::OP_SAMPLE, 16'd5, -16384, 16384, -16384, 16384);
      drain();
      // count lowered to the number of samples already taken
      write_reg(qce_pkg::REG_SAMPLE_COUNT, 16'd1);
      send_word(qce_pkg::OP_SAMPLE, 16'd5, -16384, 16384, -16384, 16384);
      send_word(qce_pkg::OP_MEASURE, 16'd0, -12000, 7000, -3000, 16384);
      send_word(qce_pkg::OP_CLEAR, 16'd0, 0, 0, 0, 0);
      drain();
      write_reg(qce_pkg::REG_SAMPLE_COUNT, 16'd0);
      write_reg(qce_pkg::REG_TARGET_BODY, 16'hffff);
      target = 16'hffff;
      send_word(qce_pkg::OP_SAMPLE, 16'hffff, 16384, -1, 1, -1);
      send_word(qce_pkg::OP_MEASURE, 16'd0, 16384, 0, 0, 0);
      send_word(qce_pkg::OP_CLEAR, 16'd0, 0, 0, 0, 0);
      drain();
      write_reg(qce_pkg::REG_SAMPLE_COUNT, 16'h1fff);
      send_word(qce_pkg::OP_SAMPLE, 16'hffff, 16384, 0, 0, 0);
      send_word(qce_pkg::OP_MEASURE, 16'd0, 100, 200, 300, 400);
      send_word(qce_pkg::OP_CLEAR, 16'd0, 0, 0, 0, 0);

      // random phases, each with its own register setting
      while (words_sent < 730) begin
         drain();
         c = $urandom_range(0, 9);
         if (c == 0) begin
            write_reg(qce_pkg::REG_SAMPLE_COUNT, 16'd0);
         end else if (c == 1) begin
            write_reg(qce_pkg::REG_SAMPLE_COUNT, 16'($urandom_range(0, 1) ? 4096 : 8191));
         end else begin
            write_reg(qce_pkg::REG_SAMPLE_COUNT, 16'($urandom_range(1, 6)));
         end
         if ($urandom_range(0, 2) == 0) begin
            c = $urandom_range(0, 3);
            target = (c == 0) ? 16'd0 : (c == 1) ? 16'hffff : 16'($urandom);
            write_reg(qce_pkg::REG_TARGET_BODY, target);
         end
         send_word(qce_pkg::OP_CLEAR, target, 0, 0, 0, 0);
         repeat ($urandom_range(15, 40)) random_word();
      end

      drain();
      repeat (300) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
